// ===== sv/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and codes for the buddy block allocator: transaction payloads,
// status codes, datapath operation codes and controller status.
// ----------------------------------------------------------------------------
package bba_pkg;

  // log2 of the largest heap; sets memory depth and address width
  localparam int MAX_ORDER = 10;

  localparam int ADDR_W = MAX_ORDER;
  localparam int ORD_W  = 4;
  localparam int ST_W   = 2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_NOMEM = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD   = 2'd2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [ORD_W-1:0]  req_order;
    logic [ADDR_W-1:0] block_addr;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_addr;
    logic [ST_W-1:0]   status;
  } out_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_CLR_START,
    OP_CLR_STEP,
    OP_LOAD,
    OP_SEARCH,
    OP_TAKE,
    OP_UL_HEAD,
    OP_UL_PREV,
    OP_UL_CLR,
    OP_SPLIT,
    OP_PUSH,
    OP_PUSH_LINK,
    OP_ALLOC_FIN,
    OP_RD_BUD,
    OP_MERGE,
    OP_SETX,
    OP_FREE_FIN,
    OP_SET_BAD,
    OP_SET_NOMEM
  } dp_op_e;

  typedef struct packed {
    logic clr_last;
    logic mode_free;
    logic s_gt_tot;
    logic s_lt_tot;
    logic s_gt_ord;
    logic head_nil;
    logic bad_free;
    logic buddy_ok;
  } dp_stat_t;

  typedef struct packed {
    dp_op_e op;
    logic   in_stall;
    logic   out_valid;
  } ctl_t;

endpackage

// ===== sv/buddy_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// buddy_block_allocator_core
// Buddy allocator over 2^total_order units with per-order LIFO free lists.
// ----------------------------------------------------------------------------
// One transaction at a time. After reset, and after every write of
// total_order, the block runs a clearing pass over all 2^MAX_ORDER
// link-table entries (one entry per cycle) with in_stall_o high; then it
// holds one free block of order total_order at unit 0. The steps of an
// allocate or free work on the link memories, so the cost is set by the
// number of list operations: an allocate grows with the empty orders
// skipped and the splits, an out-of-space allocate with the empty orders
// skipped, a free with the merges, and a refused free does no list work;
// every result may then wait to be taken. Status 1 means no block large
// enough, status 2 a refused free; both return address 0.
module buddy_block_allocator_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  // request channel
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bba_pkg::in_t  in_data_i,
  // result channel
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bba_pkg::out_t out_data_o,
  // register port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int MAX_ORDER = bba_pkg::MAX_ORDER;
  localparam int OW = $clog2(MAX_ORDER + 1);

  bba_pkg::ctl_t     ctl;
  bba_pkg::dp_stat_t stat;
  logic              cfg_we;
  logic [OW-1:0]     cfg_order, total_order;

  // total_order is register 0 (byte address 0); only pwdata[3:0] is used, values above MAX_ORDER saturate
  assign pready    = 1'b1;
  assign cfg_we    = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign cfg_order = (pwdata[3:0] > 4'(MAX_ORDER)) ? OW'(MAX_ORDER) : OW'(pwdata[3:0]);
  assign prdata    = (paddr[2] == 1'b0) ? 32'(total_order) : '0;

  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .cfg_we_i    (cfg_we),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  bba_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (ctl.op),
    .in_data_i     (in_data_i),
    .cfg_we_i      (cfg_we),
    .cfg_order_i   (cfg_order),
    .total_order_o (total_order),
    .stat_o        (stat),
    .out_data_o    (out_data_o)
  );

  assign in_stall_o  = ctl.in_stall;
  assign out_valid_o = ctl.out_valid;

endmodule

// ===== sv/bba_dp.sv =====
// ----------------------------------------------------------------------------
// bba_dp
// Datapath: free-list heads, per-unit link/flag/order memories, working
// registers and the result register. Executes one operation per cycle.
// ----------------------------------------------------------------------------
module bba_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bba_pkg::dp_op_e         op_i,
  input  bba_pkg::in_t            in_data_i,
  input  logic                    cfg_we_i,
  input  logic [$clog2(bba_pkg::MAX_ORDER+1)-1:0] cfg_order_i,
  output logic [$clog2(bba_pkg::MAX_ORDER+1)-1:0] total_order_o,
  output bba_pkg::dp_stat_t       stat_o,
  output bba_pkg::out_t           out_data_o
);

  localparam int MAX_ORDER = bba_pkg::MAX_ORDER;
  localparam int AW    = MAX_ORDER;
  localparam int LW    = AW + 1;
  localparam int UNITS = 1 << AW;
  localparam int OW    = $clog2(MAX_ORDER + 1);
  localparam int SW    = ($clog2(MAX_ORDER + 2) > bba_pkg::ORD_W) ?
                         $clog2(MAX_ORDER + 2) : bba_pkg::ORD_W;
  localparam int IW    = ((MAX_ORDER > bba_pkg::ADDR_W) ? MAX_ORDER : bba_pkg::ADDR_W) + 1;
  localparam int RST_TOT = (MAX_ORDER < 10) ? MAX_ORDER : 10;
  localparam logic [LW-1:0] NIL = LW'(1) << AW;

  // per-unit memories
  logic [LW-1:0] nxt_mem  [UNITS];
  logic [LW-1:0] prv_mem  [UNITS];
  logic          free_mem [UNITS];
  logic [OW-1:0] ord_mem  [UNITS];

  logic [LW-1:0] head_q [MAX_ORDER+1];

  logic [OW-1:0]          tot_q;
  logic [AW-1:0]          clr_q;
  logic                   mode_q;
  logic [bba_pkg::ORD_W-1:0] ord_q;
  logic [SW-1:0]          s_q;
  logic [IW-1:0]          addr_q;
  logic [AW-1:0]          a_q, b_q, x_q;
  logic [LW-1:0]          n_q, p_q, h_q;
  bba_pkg::out_t          res_q;

  logic [LW-1:0] rd_nxt_q, rd_prv_q;
  logic          rd_free_q;
  logic [OW-1:0] rd_ord_q;

  logic [AW-1:0] raddr, waddr;
  logic          we_nxt, we_prv, we_free, we_ord;
  logic [LW-1:0] wd_nxt, wd_prv;
  logic          wd_free;
  logic [OW-1:0] wd_ord;
  logic [OW-1:0] s_idx;
  logic [LW-1:0] head_s;
  logic [IW-1:0] size, lim;

  assign s_idx  = s_q[OW-1:0];
  assign head_s = head_q[s_idx];
  assign size   = IW'(1) << ord_q;
  assign lim    = IW'(1) << tot_q;

  // read address per operation
  always_comb begin
    unique case (op_i)
      bba_pkg::OP_LOAD:   raddr = AW'(in_data_i.block_addr);
      bba_pkg::OP_TAKE:   raddr = head_s[AW-1:0];
      bba_pkg::OP_RD_BUD: raddr = a_q ^ (AW'(1) << s_q);
      default:            raddr = a_q;
    endcase
  end

  // memory write port
  always_comb begin
    waddr   = a_q;
    we_nxt  = 1'b0;
    we_prv  = 1'b0;
    we_free = 1'b0;
    we_ord  = 1'b0;
    wd_nxt  = NIL;
    wd_prv  = NIL;
    wd_free = 1'b0;
    wd_ord  = '0;
    unique case (op_i)
      bba_pkg::OP_CLR_STEP: begin
        waddr   = clr_q;
        we_nxt  = 1'b1;
        we_prv  = 1'b1;
        we_free = 1'b1;
        we_ord  = 1'b1;
        wd_free = (clr_q == '0);
        wd_ord  = (clr_q == '0) ? tot_q : '0;
      end
      bba_pkg::OP_UL_HEAD: begin
        waddr  = rd_prv_q[AW-1:0];
        we_nxt = !rd_prv_q[AW];
        wd_nxt = rd_nxt_q;
      end
      bba_pkg::OP_UL_PREV: begin
        waddr  = n_q[AW-1:0];
        we_prv = !n_q[AW];
        wd_prv = p_q;
      end
      bba_pkg::OP_UL_CLR: begin
        waddr   = b_q;
        we_nxt  = 1'b1;
        we_prv  = 1'b1;
        we_free = 1'b1;
      end
      bba_pkg::OP_PUSH: begin
        waddr   = x_q;
        we_nxt  = 1'b1;
        we_prv  = 1'b1;
        we_free = 1'b1;
        we_ord  = 1'b1;
        wd_nxt  = head_s;
        wd_free = 1'b1;
        wd_ord  = s_idx;
      end
      bba_pkg::OP_PUSH_LINK: begin
        waddr  = h_q[AW-1:0];
        we_prv = !h_q[AW];
        wd_prv = LW'(x_q);
      end
      bba_pkg::OP_ALLOC_FIN: begin
        waddr  = a_q;
        we_ord = 1'b1;
        wd_ord = OW'(ord_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_nxt) begin
      nxt_mem[waddr] <= wd_nxt;
    end
    rd_nxt_q <= nxt_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (we_prv) begin
      prv_mem[waddr] <= wd_prv;
    end
    rd_prv_q <= prv_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (we_free) begin
      free_mem[waddr] <= wd_free;
    end
    rd_free_q <= free_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (we_ord) begin
      ord_mem[waddr] <= wd_ord;
    end
    rd_ord_q <= ord_mem[raddr];
  end

  // list heads
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      bba_pkg::OP_CLR_START: begin
        for (int i = 0; i <= MAX_ORDER; i++) begin
          head_q[i] <= NIL;
        end
      end
      bba_pkg::OP_CLR_STEP: begin
        if (clr_q == '0) begin
          head_q[tot_q] <= '0;
        end
      end
      bba_pkg::OP_UL_HEAD: begin
        if (rd_prv_q[AW]) begin
          head_q[rd_ord_q] <= rd_nxt_q;
        end
      end
      bba_pkg::OP_PUSH: head_q[s_idx] <= LW'(x_q);
      default: ;
    endcase
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q <= OW'(RST_TOT);
    end else if (cfg_we_i) begin
      tot_q <= cfg_order_i;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      bba_pkg::OP_CLR_START: clr_q <= '0;
      bba_pkg::OP_CLR_STEP:  clr_q <= clr_q + AW'(1);
      bba_pkg::OP_LOAD: begin
        mode_q <= in_data_i.mode;
        ord_q  <= in_data_i.req_order;
        s_q    <= SW'(in_data_i.req_order);
        addr_q <= IW'(in_data_i.block_addr);
        a_q    <= AW'(in_data_i.block_addr);
      end
      bba_pkg::OP_SEARCH: s_q <= s_q + SW'(1);
      bba_pkg::OP_TAKE: begin
        a_q <= head_s[AW-1:0];
        b_q <= head_s[AW-1:0];
      end
      bba_pkg::OP_RD_BUD: b_q <= a_q ^ (AW'(1) << s_q);
      bba_pkg::OP_UL_HEAD: begin
        n_q <= rd_nxt_q;
        p_q <= rd_prv_q;
      end
      bba_pkg::OP_SPLIT: begin
        s_q <= s_q - SW'(1);
        x_q <= a_q + (AW'(1) << (s_q - SW'(1)));
      end
      bba_pkg::OP_PUSH: h_q <= head_s;
      bba_pkg::OP_MERGE: begin
        if (b_q < a_q) begin
          a_q <= b_q;
        end
        s_q <= s_q + SW'(1);
      end
      bba_pkg::OP_SETX: x_q <= a_q;
      bba_pkg::OP_ALLOC_FIN, bba_pkg::OP_FREE_FIN: begin
        res_q.result_addr <= bba_pkg::ADDR_W'(a_q);
        res_q.status      <= bba_pkg::ST_OK;
      end
      bba_pkg::OP_SET_BAD: begin
        res_q.result_addr <= '0;
        res_q.status      <= bba_pkg::ST_BAD;
      end
      bba_pkg::OP_SET_NOMEM: begin
        res_q.result_addr <= '0;
        res_q.status      <= bba_pkg::ST_NOMEM;
      end
      default: ;
    endcase
  end

  // status toward the controller
  always_comb begin
    stat_o.clr_last  = &clr_q;
    stat_o.mode_free = (mode_q == bba_pkg::MODE_FREE);
    stat_o.s_gt_tot  = s_q > SW'(tot_q);
    stat_o.s_lt_tot  = s_q < SW'(tot_q);
    stat_o.s_gt_ord  = s_q > SW'(ord_q);
    stat_o.head_nil  = head_s[AW];
    stat_o.bad_free  = (SW'(ord_q) > SW'(tot_q)) || ((addr_q + size) > lim) ||
                       ((addr_q & (size - IW'(1))) != '0) || rd_free_q ||
                       (SW'(rd_ord_q) != SW'(ord_q));
    stat_o.buddy_ok  = rd_free_q && (SW'(rd_ord_q) == s_q);
  end

  assign total_order_o = tot_q;
  assign out_data_o    = res_q;

endmodule

// ===== sv/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl
// Controller: sequences clearing, search, unlink, split, merge and push
// steps of the datapath and runs both transaction handshakes.
// ----------------------------------------------------------------------------
module bba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_stall_i,
  input  logic              cfg_we_i,
  input  bba_pkg::dp_stat_t stat_i,
  output bba_pkg::ctl_t     ctl_o
);

  localparam logic [3:0] S_CLR0  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_IDLE  = 4'd2;
  localparam logic [3:0] S_DISP  = 4'd3;
  localparam logic [3:0] S_ASRCH = 4'd4;
  localparam logic [3:0] S_UL0   = 4'd5;
  localparam logic [3:0] S_UL1   = 4'd6;
  localparam logic [3:0] S_UL2   = 4'd7;
  localparam logic [3:0] S_ASPL  = 4'd8;
  localparam logic [3:0] S_PUSH  = 4'd9;
  localparam logic [3:0] S_PUSH2 = 4'd10;
  localparam logic [3:0] S_FLOOP = 4'd11;
  localparam logic [3:0] S_FCHK  = 4'd12;
  localparam logic [3:0] S_FMRG  = 4'd13;
  localparam logic [3:0] S_FFIN  = 4'd14;
  localparam logic [3:0] S_OUT   = 4'd15;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d         = state_q;
    ctl_o.op        = bba_pkg::OP_NOP;
    ctl_o.in_stall  = 1'b1;
    ctl_o.out_valid = 1'b0;
    unique case (state_q)
      S_CLR0: begin
        ctl_o.op = bba_pkg::OP_CLR_START;
        state_d  = S_CLR;
      end
      S_CLR: begin
        ctl_o.op = bba_pkg::OP_CLR_STEP;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        ctl_o.in_stall = 1'b0;
        if (in_valid_i) begin
          ctl_o.op = bba_pkg::OP_LOAD;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        if (!stat_i.mode_free) begin
          state_d = S_ASRCH;
        end else if (stat_i.bad_free) begin
          ctl_o.op = bba_pkg::OP_SET_BAD;
          state_d  = S_OUT;
        end else begin
          state_d = S_FLOOP;
        end
      end
      S_ASRCH: begin
        priority if (stat_i.s_gt_tot) begin
          ctl_o.op = bba_pkg::OP_SET_NOMEM;
          state_d  = S_OUT;
        end else if (stat_i.head_nil) begin
          ctl_o.op = bba_pkg::OP_SEARCH;
        end else begin
          ctl_o.op = bba_pkg::OP_TAKE;
          state_d  = S_UL0;
        end
      end
      S_UL0: begin
        ctl_o.op = bba_pkg::OP_UL_HEAD;
        state_d  = S_UL1;
      end
      S_UL1: begin
        ctl_o.op = bba_pkg::OP_UL_PREV;
        state_d  = S_UL2;
      end
      S_UL2: begin
        ctl_o.op = bba_pkg::OP_UL_CLR;
        state_d  = stat_i.mode_free ? S_FMRG : S_ASPL;
      end
      S_ASPL: begin
        if (stat_i.s_gt_ord) begin
          ctl_o.op = bba_pkg::OP_SPLIT;
          state_d  = S_PUSH;
        end else begin
          ctl_o.op = bba_pkg::OP_ALLOC_FIN;
          state_d  = S_OUT;
        end
      end
      S_PUSH: begin
        ctl_o.op = bba_pkg::OP_PUSH;
        state_d  = S_PUSH2;
      end
      S_PUSH2: begin
        ctl_o.op = bba_pkg::OP_PUSH_LINK;
        state_d  = stat_i.mode_free ? S_FFIN : S_ASPL;
      end
      S_FLOOP: begin
        if (stat_i.s_lt_tot) begin
          ctl_o.op = bba_pkg::OP_RD_BUD;
          state_d  = S_FCHK;
        end else begin
          ctl_o.op = bba_pkg::OP_SETX;
          state_d  = S_PUSH;
        end
      end
      S_FCHK: begin
        if (stat_i.buddy_ok) begin
          ctl_o.op = bba_pkg::OP_UL_HEAD;
          state_d  = S_UL1;
        end else begin
          ctl_o.op = bba_pkg::OP_SETX;
          state_d  = S_PUSH;
        end
      end
      S_FMRG: begin
        ctl_o.op = bba_pkg::OP_MERGE;
        state_d  = S_FLOOP;
      end
      S_FFIN: begin
        ctl_o.op = bba_pkg::OP_FREE_FIN;
        state_d  = S_OUT;
      end
      S_OUT: begin
        ctl_o.out_valid = 1'b1;
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLR0;
    endcase
    if (cfg_we_i) begin
      state_d = S_CLR0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR0;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== verif/bba_checker.sv =====
// ----------------------------------------------------------------------------
// bba_checker
// Watches the request and result channels of the buddy allocator, keeps its
// own copy of the free lists and checks every result in order.
// ----------------------------------------------------------------------------
module bba_checker #(
  parameter int MAX_ORDER = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  bba_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  bba_pkg::out_t out_data_i,
  input  logic          cfg_we_i,
  input  logic [3:0]    cfg_order_i,
  output int            fail_cnt_o,
  output int            pending_o,
  output int            seen_cnt_o,
  output int            ok_cnt_o,
  output int            nomem_cnt_o,
  output int            bad_cnt_o,
  output int            merge_cnt_o
);

  localparam int UNITS = 1 << MAX_ORDER;
  localparam int NIL   = UNITS;

  int   tot_ord;
  int   head_q [MAX_ORDER+1];
  int   nxt [UNITS];
  int   prv [UNITS];
  bit   is_free [UNITS];
  int   blk_ord [UNITS];
  bba_pkg::out_t expected_q [$];

  function automatic void push_blk(input int o, input int a);
    nxt[a] = head_q[o];
    prv[a] = NIL;
    if (head_q[o] != NIL) prv[head_q[o]] = a;
    head_q[o] = a;
    is_free[a] = 1'b1;
    blk_ord[a] = o;
  endfunction

  function automatic void unlink_blk(input int a);
    int n;
    int p;
    n = nxt[a];
    p = prv[a];
    if (p == NIL) begin
      if (blk_ord[a] <= MAX_ORDER) head_q[blk_ord[a]] = n;
    end else begin
      nxt[p] = n;
    end
    if (n != NIL) prv[n] = p;
    nxt[a] = NIL;
    prv[a] = NIL;
    is_free[a] = 1'b0;
  endfunction

  function automatic void reinit_heap(input int o);
    for (int i = 0; i <= MAX_ORDER; i++) head_q[i] = NIL;
    for (int i = 0; i < UNITS; i++) begin
      nxt[i] = NIL;
      prv[i] = NIL;
      is_free[i] = 1'b0;
      blk_ord[i] = 0;
    end
    tot_ord = (o > MAX_ORDER) ? MAX_ORDER : o;
    push_blk(tot_ord, 0);
  endfunction

  function automatic bba_pkg::out_t serve_request(input bba_pkg::in_t rq);
    bba_pkg::out_t r;
    int   o;
    int   s;
    int   a;
    int   b;
    int   sz;
    r = '0;
    r.status = bba_pkg::ST_OK;
    o = int'(rq.req_order);
    a = int'(rq.block_addr);
    if (rq.mode == bba_pkg::MODE_ALLOC) begin
      s = o;
      while (s <= tot_ord && head_q[s] == NIL) s++;
      if (s > tot_ord) begin
        r.status = bba_pkg::ST_NOMEM;
      end else begin
        a = head_q[s];
        unlink_blk(a);
        while (s > o) begin
          s--;
          push_blk(s, a + (1 << s));
        end
        blk_ord[a] = o;
        r.result_addr = bba_pkg::ADDR_W'(a);
      end
    end else if (o > tot_ord) begin
      r.status = bba_pkg::ST_BAD;
    end else begin
      sz = 1 << o;
      if (a + sz > (1 << tot_ord) || (a & (sz - 1)) != 0 || is_free[a]
          || blk_ord[a] != o) begin
        r.status = bba_pkg::ST_BAD;
      end else begin
        while (o < tot_ord) begin
          b = a ^ (1 << o);
          if (!is_free[b] || blk_ord[b] != o) break;
          unlink_blk(b);
          merge_cnt_o++;
          if (b < a) a = b;
          o++;
        end
        push_blk(o, a);
        r.result_addr = bba_pkg::ADDR_W'(a);
      end
    end
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    bba_pkg::out_t exp_r;
    if (!rst_ni) begin
      reinit_heap(10);
      expected_q.delete();
      fail_cnt_o  <= 0;
      seen_cnt_o  <= 0;
      ok_cnt_o    <= 0;
      nomem_cnt_o <= 0;
      bad_cnt_o   <= 0;
      merge_cnt_o = 0;
    end else begin
      if (cfg_we_i) reinit_heap(int'(cfg_order_i));
      if (out_valid_i && !out_stall_i) begin
        seen_cnt_o <= seen_cnt_o + 1;
        if (expected_q.size() == 0) begin
          if (fail_cnt_o < 10) $display("ERROR: unexpected result %p", out_data_i);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          exp_r = expected_q.pop_front();
          case (exp_r.status)
            bba_pkg::ST_OK:    ok_cnt_o    <= ok_cnt_o + 1;
            bba_pkg::ST_NOMEM: nomem_cnt_o <= nomem_cnt_o + 1;
            default:           bad_cnt_o   <= bad_cnt_o + 1;
          endcase
          if (exp_r.result_addr !== out_data_i.result_addr
              || exp_r.status !== out_data_i.status) begin
            if (fail_cnt_o < 10)
              $display("ERROR: result mismatch: expected addr %0d st %0d, got addr %0d st %0d",
                       exp_r.result_addr, exp_r.status,
                       out_data_i.result_addr, out_data_i.status);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(serve_request(in_data_i));
    end
  end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the buddy allocator: directed corner cases, then
// random alloc/free traffic over several heap sizes and idling phases.
// ----------------------------------------------------------------------------
module tb;

  localparam int MAX_ORDER = bba_pkg::MAX_ORDER;
  localparam int RAND_ITEMS = 1950;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  bba_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  bba_pkg::out_t out_data;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [2:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  int fail_cnt, pending, seen_cnt, ok_cnt, nomem_cnt, bad_cnt, merge_cnt;
  int cycle_cnt = 0;

  // idling knobs, in percent; hold_off forces a long receiver stall
  int  src_idle_pct = 0;
  int  sink_stall_pct = 0;
  bit  hold_off = 1'b0;
  int  cur_tot = 10;
  int  sent_cnt = 0;

  // live allocations, used to build mostly legal frees
  int  live_addr [$];
  int  live_ord [$];

  // orders of accepted allocates and modes of accepted requests, in order
  int   pend_ord [$];
  logic mode_q [$];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  buddy_block_allocator_core dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  bba_checker #(.MAX_ORDER(MAX_ORDER)) chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_we_i(psel && penable && pwrite && pready && paddr[2] == 1'b0),
    .cfg_order_i(pwdata[3:0]),
    .fail_cnt_o(fail_cnt), .pending_o(pending), .seen_cnt_o(seen_cnt),
    .ok_cnt_o(ok_cnt), .nomem_cnt_o(nomem_cnt), .bad_cnt_o(bad_cnt),
    .merge_cnt_o(merge_cnt)
  );

  // watchdog: worst case ~2000 items plus long stalls and clears
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 1000000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off counted here
  always @(posedge clk_i) begin
    int hold_cycles;
    if (hold_off) begin
      out_stall <= 1'b1;
      for (hold_cycles = 0; hold_cycles < 400; hold_cycles++) @(posedge clk_i);
      hold_off = 1'b0;
    end
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  // one transaction; valid stays high between back-to-back items
  task automatic send_req(input logic m, input int o, input int a);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data.mode       <= m;
    in_data.req_order  <= o[bba_pkg::ORD_W-1:0];
    in_data.block_addr <= a[bba_pkg::ADDR_W-1:0];
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sent_cnt++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // a freshly accepted item may still be in flight; wait out the latency
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_order(input int o);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= 32'(o);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    cur_tot = (o > MAX_ORDER) ? MAX_ORDER : o;
    live_addr.delete();
    live_ord.delete();
  endtask

  // allocations are tracked from the result channel; the checker knows the truth, and a
  // free of a stale guess just exercises the refusal path
  task automatic alloc_req(input int o);
    send_req(bba_pkg::MODE_ALLOC, o, int'($urandom_range(1023)));
  endtask

  task automatic rand_item;
    int r;
    int k;
    r = int'($urandom_range(99));
    if (r < 45) begin
      alloc_req(int'($urandom_range(cur_tot < 3 ? cur_tot : 3)));
    end else if (r < 85 && live_addr.size() > 0) begin
      k = int'($urandom_range(live_addr.size() - 1));
      send_req(bba_pkg::MODE_FREE, live_ord[k], live_addr[k]);
      live_addr.delete(k);
      live_ord.delete(k);
    end else begin
      send_req(1'($urandom_range(1)), int'($urandom_range(15)),
               int'($urandom_range(1023)));
    end
  endtask

  // tracks successful allocations from the result channel
  always @(posedge clk_i) begin
    if (in_valid && !in_stall) begin
      mode_q.push_back(in_data.mode);
      if (in_data.mode == bba_pkg::MODE_ALLOC) pend_ord.push_back(int'(in_data.req_order));
    end
    if (out_valid && !out_stall && mode_q.size() > 0) begin
      if (mode_q[0] == bba_pkg::MODE_ALLOC && pend_ord.size() > 0) begin
        if (out_data.status == bba_pkg::ST_OK) begin
          live_addr.push_back(int'(out_data.result_addr));
          live_ord.push_back(pend_ord[0]);
        end
        void'(pend_ord.pop_front());
      end
      void'(mode_q.pop_front());
    end
  end

  initial begin
    int ph;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: full heap alloc, double free, misalignment, range, mismatch
    send_req(bba_pkg::MODE_ALLOC, 10, 0);
    send_req(bba_pkg::MODE_ALLOC, 0, 0);
    send_req(bba_pkg::MODE_FREE, 10, 0);
    send_req(bba_pkg::MODE_FREE, 10, 0);
    send_req(bba_pkg::MODE_ALLOC, 0, 1023);
    send_req(bba_pkg::MODE_ALLOC, 3, 0);
    send_req(bba_pkg::MODE_FREE, 3, 0);
    send_req(bba_pkg::MODE_FREE, 0, 0);
    send_req(bba_pkg::MODE_FREE, 0, 1);
    send_req(bba_pkg::MODE_FREE, 2, 6);
    send_req(bba_pkg::MODE_FREE, 15, 1023);
    send_req(bba_pkg::MODE_ALLOC, 15, 0);
    send_req(bba_pkg::MODE_ALLOC, 11, 0);
    send_req(bba_pkg::MODE_FREE, 0, 0);
    send_req(bba_pkg::MODE_ALLOC, 0, 0);
    write_order(0);
    send_req(bba_pkg::MODE_ALLOC, 0, 0);
    send_req(bba_pkg::MODE_ALLOC, 0, 0);
    send_req(bba_pkg::MODE_FREE, 0, 1);
    send_req(bba_pkg::MODE_FREE, 0, 0);
    write_order(15);
    send_req(bba_pkg::MODE_ALLOC, 10, 0);
    write_order(2);
    send_req(bba_pkg::MODE_FREE, 2, 0);
    send_req(bba_pkg::MODE_ALLOC, 3, 0);

    // random phases over several heap sizes and idling mixes
    for (ph = 0; ph < 8; ph++) begin
      write_order(ph == 0 ? 10 : ph == 1 ? 0 : ph == 2 ? 1 : int'($urandom_range(2, 10)));
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 71; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 71; end
        default: begin src_idle_pct = 12; sink_stall_pct = 12; end
      endcase
      if (ph == 3) hold_off = 1'b1;
      repeat (RAND_ITEMS / 8) begin
        rand_item();
        if ($urandom_range(299) == 0) drain();
      end
    end
    write_order(10);

    drain();
    $display("Run covered %0d requests: %0d ok, %0d out of space, %0d refused, %0d merges.",
             sent_cnt, ok_cnt, nomem_cnt, bad_cnt, merge_cnt);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== buddy_block_allocator_core.f =====
sv/bba_pkg.sv
sv/bba_dp.sv
sv/bba_ctrl.sv
sv/buddy_block_allocator_core.sv
verif/bba_checker.sv
verif/tb.sv
